/* sv/pls_pkg.sv */
// Shared types and constants for the positional list store.
// Sizes, command and status codes, and the sequencer state type.
// No dependencies.
`default_nettype none

package pls_pkg;

  localparam int CAPACITY = 16;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 2 * DATA_W;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  // width used to compare a request position against the fill count
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RETRIEVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_UP,
    S_INS_HEAD,
    S_SEARCH,
    S_READ_CAP,
    S_REMOVE_CAP,
    S_SHIFT_DOWN,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

/* sv/positional_list_store.sv */
// Positional list store: ordered list of (id, priority) words with search.
// Holds the entry memory and the sequencer that walks it one entry a cycle.
// Depends on pls_pkg.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready) carries command, entry_id,
//   entry_priority and position. Result channel (res_valid/res_ready)
//   carries status, found_position, out_id, out_priority, entry_count.
//   Exactly one result word per command word.
// Sequencing:
//   One command at a time; cmd_ready is high only while idle. The entry
//   memory has one write port and one registered read port,
//   so walks advance one entry per cycle:
//     push back, clear, spare codes, bad position, full: dispatch, result
//     retrieve: dispatch, read capture, result; search: head-first walk
//     to the first match or the count; push front: shift-up walk from the
//     tail, then head insert; remove: capture, shift-down walk to the count
// Reset: rst (synchronous) empties the list; entry contents are not
//   cleared, entries past the count are never read.
// Stall: a result holds in its output register until res_ready; no new
//   command is taken meanwhile.
`default_nettype none

module positional_list_store (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cmd_valid,
  output logic                                cmd_ready,
  input  wire        [pls_pkg::CMD_W-1:0]     command,
  input  wire signed [pls_pkg::DATA_W-1:0]    entry_id,
  input  wire signed [pls_pkg::DATA_W-1:0]    entry_priority,
  input  wire        [pls_pkg::POS_W-1:0]     position,
  output logic                                res_valid,
  input  wire                                 res_ready,
  output logic       [pls_pkg::STAT_W-1:0]    status,
  output logic       [pls_pkg::POS_W-1:0]     found_position,
  output logic signed [pls_pkg::DATA_W-1:0]   out_id,
  output logic signed [pls_pkg::DATA_W-1:0]   out_priority,
  output logic       [pls_pkg::COUNT_W-1:0]   entry_count
);
  import pls_pkg::*;

  // entry memory: {id, priority}
  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rdata;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;

  state_t state, state_next;

  // latched command word
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] key_id;
  logic [DATA_W-1:0] key_pri;
  logic [POS_W-1:0]  pos;

  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  src, src_next;
  logic              pend, pend_next;

  logic [STAT_W-1:0]  status_next;
  logic [POS_W-1:0]   found_next;
  logic [DATA_W-1:0]  oid_next;
  logic [DATA_W-1:0]  opri_next;

  logic               full;
  logic               bad_pos;
  logic               idx_lt_cnt;
  logic               match;
  logic [CMP_W-1:0]   pos_wide;
  logic [CMP_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   idx_dec;
  logic [IDX_W-1:0]   src_inc;
  logic [IDX_W-1:0]   src_dec;
  logic [CNT_W-1:0]   idx_inc;

  assign full       = (count == CNT_W'(CAPACITY));
  assign pos_wide   = CMP_W'(pos);
  assign pos_inc    = pos_wide + CMP_W'(1);
  assign bad_pos    = (pos_wide >= CMP_W'(count));
  assign idx_lt_cnt = (idx < count);
  assign idx_dec    = idx - CNT_W'(1);
  assign idx_inc    = idx + CNT_W'(1);
  assign src_inc    = src + IDX_W'(1);
  assign src_dec    = src - IDX_W'(1);
  // the one id comparator: id of the word read last cycle against the key
  assign match      = pend && (rdata[ENTRY_W-1:DATA_W] == key_id);

  assign cmd_ready   = (state == S_IDLE);
  assign res_valid   = (state == S_RESULT);
  assign entry_count = COUNT_W'(count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cmd)
          CMD_PUSH_FRONT: begin
            if (full) state_next = S_RESULT;
            else if (count == '0) state_next = S_INS_HEAD;
            else state_next = S_SHIFT_UP;
          end
          CMD_SEARCH: state_next = S_SEARCH;
          CMD_RETRIEVE: begin
            state_next = bad_pos ? S_RESULT : S_READ_CAP;
          end
          CMD_REMOVE: begin
            state_next = bad_pos ? S_RESULT : S_REMOVE_CAP;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_SHIFT_UP: begin
        if (idx == '0) state_next = S_INS_HEAD;
      end
      S_INS_HEAD:   state_next = S_RESULT;
      S_SEARCH: begin
        if (match || !idx_lt_cnt) state_next = S_RESULT;
      end
      S_READ_CAP:   state_next = S_RESULT;
      S_REMOVE_CAP: state_next = S_SHIFT_DOWN;
      S_SHIFT_DOWN: begin
        if (!idx_lt_cnt) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_next  = count;
    idx_next    = idx;
    src_next    = src;
    pend_next   = pend;
    status_next = status;
    found_next  = found_position;
    oid_next    = out_id;
    opri_next   = out_priority;
    raddr       = src;
    we          = 1'b0;
    waddr       = src;
    wdata       = rdata;
    case (state)
      S_DISPATCH: begin
        status_next = STAT_OK;
        found_next  = '0;
        oid_next    = '0;
        opri_next   = '0;
        pend_next   = 1'b0;
        case (cmd)
          CMD_PUSH_BACK: begin
            if (full) begin
              status_next = STAT_FULL;
            end else begin
              we         = 1'b1;
              waddr      = count[IDX_W-1:0];
              wdata      = {key_id, key_pri};
              count_next = count + CNT_W'(1);
            end
          end
          CMD_PUSH_FRONT: begin
            if (full) status_next = STAT_FULL;
            idx_next = count;
          end
          CMD_SEARCH: begin
            idx_next = '0;
          end
          CMD_RETRIEVE: begin
            if (bad_pos) status_next = STAT_BAD_POS;
            raddr = pos_wide[IDX_W-1:0];
          end
          CMD_REMOVE: begin
            if (bad_pos) status_next = STAT_BAD_POS;
            raddr    = pos_wide[IDX_W-1:0];
            idx_next = pos_inc[CNT_W-1:0];
          end
          CMD_CLEAR: begin
            count_next = '0;
          end
          default: ;
        endcase
      end
      S_SHIFT_UP: begin
        // word read last cycle moves one place toward the back
        if (pend) begin
          we    = 1'b1;
          waddr = src_inc;
        end
        if (idx != '0) begin
          raddr     = idx_dec[IDX_W-1:0];
          src_next  = idx_dec[IDX_W-1:0];
          idx_next  = idx_dec;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      S_INS_HEAD: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = {key_id, key_pri};
        count_next = count + CNT_W'(1);
      end
      S_SEARCH: begin
        if (match) begin
          found_next = POS_W'(src);
        end else if (idx_lt_cnt) begin
          raddr     = idx[IDX_W-1:0];
          src_next  = idx[IDX_W-1:0];
          idx_next  = idx_inc;
          pend_next = 1'b1;
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      S_READ_CAP: begin
        oid_next  = rdata[ENTRY_W-1:DATA_W];
        opri_next = rdata[DATA_W-1:0];
      end
      S_REMOVE_CAP: begin
        oid_next  = rdata[ENTRY_W-1:DATA_W];
        opri_next = rdata[DATA_W-1:0];
        pend_next = 1'b0;
      end
      S_SHIFT_DOWN: begin
        // word read last cycle moves one place toward the front
        if (pend) begin
          we    = 1'b1;
          waddr = src_dec;
        end
        if (idx_lt_cnt) begin
          raddr     = idx[IDX_W-1:0];
          src_next  = idx[IDX_W-1:0];
          idx_next  = idx_inc;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          count_next = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cmd     <= command;
      key_id  <= entry_id;
      key_pri <= entry_priority;
      pos     <= position;
    end
    idx            <= idx_next;
    src            <= src_next;
    status         <= status_next;
    found_position <= found_next;
    out_id         <= oid_next;
    out_priority   <= opri_next;
  end

endmodule

`default_nettype wire

/* tb/sv/list_store_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the positional list store: keeps its own copy of the list,
// predicts one result word per accepted command word and compares in order.
// Depends on pls_pkg.

module list_store_checker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cmd_valid,
  input  wire                               cmd_ready,
  input  wire        [pls_pkg::CMD_W-1:0]   command,
  input  wire signed [pls_pkg::DATA_W-1:0]  entry_id,
  input  wire signed [pls_pkg::DATA_W-1:0]  entry_priority,
  input  wire        [pls_pkg::POS_W-1:0]   position,
  input  wire                               res_valid,
  input  wire                               res_ready,
  input  wire        [pls_pkg::STAT_W-1:0]  status,
  input  wire        [pls_pkg::POS_W-1:0]   found_position,
  input  wire signed [pls_pkg::DATA_W-1:0]  out_id,
  input  wire signed [pls_pkg::DATA_W-1:0]  out_priority,
  input  wire        [pls_pkg::COUNT_W-1:0] entry_count,
  output int                                fail_count,
  output int                                pending
);
  import pls_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   found;
    logic [DATA_W-1:0]  id;
    logic [DATA_W-1:0]  pri;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic signed [DATA_W-1:0] held_id  [CAPACITY];
  logic signed [DATA_W-1:0] held_pri [CAPACITY];
  int                       held_count;
  list_result_t             expected_results [$];

  // Update the list copy for one command word and return the result it gives.
  function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [DATA_W-1:0] id,
                                                 input logic [DATA_W-1:0] pri,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           i;
    bit           hit;
    r = '0;
    r.status = STAT_OK;
    hit = 1'b0;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (held_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          held_id[held_count]  = id;
          held_pri[held_count] = pri;
          held_count++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (held_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (i = held_count; i > 0; i--) begin
            held_id[i]  = held_id[i-1];
            held_pri[i] = held_pri[i-1];
          end
          held_id[0]  = id;
          held_pri[0] = pri;
          held_count++;
        end
      end
      CMD_SEARCH: begin
        r.status = STAT_NOT_FOUND;
        for (i = 0; i < held_count && !hit; i++) begin
          if (held_id[i] == id) begin
            hit      = 1'b1;
            r.status = STAT_OK;
            r.found  = i[POS_W-1:0];
          end
        end
      end
      CMD_RETRIEVE: begin
        if (int'(pos) >= held_count) begin
          r.status = STAT_BAD_POS;
        end else begin
          r.id  = held_id[pos];
          r.pri = held_pri[pos];
        end
      end
      CMD_REMOVE: begin
        if (int'(pos) >= held_count) begin
          r.status = STAT_BAD_POS;
        end else begin
          r.id  = held_id[pos];
          r.pri = held_pri[pos];
          for (i = int'(pos); i + 1 < held_count; i++) begin
            held_id[i]  = held_id[i+1];
            held_pri[i] = held_pri[i+1];
          end
          held_count--;
        end
      end
      CMD_CLEAR: held_count = 0;
      default: ;  // spare codes leave the list alone
    endcase
    r.count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing outstanding: status %0h, count %0d",
                 status, entry_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status);
          check_field("found_position", want.found, found_position);
          check_field("out_id", want.id, out_id);
          check_field("out_priority", want.pri, out_priority);
          check_field("entry_count", want.count, entry_count);
        end
      end
      if (cmd_valid && cmd_ready)
        expected_results.push_back(apply_command(command, entry_id, entry_priority,
                                                 position));
    end
    pending = expected_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the positional list store bench: clock, reset, command stimulus and
// result-side stalls; verdict from list_store_checker. Depends on pls_pkg.

module testbench;
  import pls_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 7;
  localparam int PHASE_WORDS  = 100;

  logic                      clk            = 1'b0;
  logic                      rst            = 1'b1;
  logic                      cmd_valid      = 1'b0;
  logic                      cmd_ready;
  logic        [CMD_W-1:0]   command        = '0;
  logic signed [DATA_W-1:0]  entry_id       = '0;
  logic signed [DATA_W-1:0]  entry_priority = '0;
  logic        [POS_W-1:0]   position       = '0;
  logic                      res_valid;
  logic                      res_ready      = 1'b0;
  logic        [STAT_W-1:0]  status;
  logic        [POS_W-1:0]   found_position;
  logic signed [DATA_W-1:0]  out_id;
  logic signed [DATA_W-1:0]  out_priority;
  logic        [COUNT_W-1:0] entry_count;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit steady      = 1'b0;  // no new gaps drawn on either side while set
  logic signed [DATA_W-1:0] id_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_store u_dut (.*);

  list_store_checker u_checker (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result side: random stalls of varying length
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Valid stays high straight into the next word when no gap is drawn.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] id,
                           input logic [DATA_W-1:0] pri, input logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid      <= 1'b1;
    command        <= cmd;
    entry_id       <= id;
    entry_priority <= pri;
    position       <= pos;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 3));
    return POS_W'($urandom_range(0, 15));
  endfunction

  // push_weight in percent; the rest leans toward removes and searches
  function automatic logic [CMD_W-1:0] pick_command(input int push_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_weight / 2) return CMD_PUSH_BACK;
    if (r < push_weight) return CMD_PUSH_FRONT;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_SEARCH;
    if (r < 50) return CMD_RETRIEVE;
    if (r < 90) return CMD_REMOVE;
    if (r < 95) return CMD_CLEAR;
    return (r < 98) ? CMD_SPARE_6 : CMD_SPARE_7;
  endfunction

  initial begin
    int phase;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h7FFF_FFFF;
    id_pool[3] = 32'h8000_0000;
    id_pool[4] = 32'h0000_0001;
    for (int k = 5; k < 8; k++) id_pool[k] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty list: no match, bad positions
    send_word(CMD_SEARCH, 32'h0000_0005, '0, '0);
    send_word(CMD_RETRIEVE, '0, '0, 4'd0);
    send_word(CMD_REMOVE, '0, '0, 4'd15);
    // extreme ids and priorities, a repeated id at the front
    send_word(CMD_PUSH_BACK, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_word(CMD_PUSH_BACK, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    send_word(CMD_PUSH_BACK, 32'hFFFF_FFFF, 32'h0000_0000, 4'd15);
    send_word(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 32'h0000_0001, '0);
    // first match wins, last entry, no match
    send_word(CMD_SEARCH, 32'h7FFF_FFFF, '0, '0);
    send_word(CMD_SEARCH, 32'hFFFF_FFFF, '0, '0);
    send_word(CMD_SEARCH, 32'h0001_2345, '0, '0);
    send_word(CMD_RETRIEVE, '0, '0, 4'd4);
    send_word(CMD_RETRIEVE, '0, '0, 4'd5);
    // remove from middle, head and tail
    send_word(CMD_REMOVE, '0, '0, 4'd2);
    send_word(CMD_REMOVE, '0, '0, 4'd0);
    send_word(CMD_REMOVE, '0, '0, 4'd2);
    send_word(CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_word(CMD_SPARE_7, '0, '0, '0);
    // fill up, then refused pushes and accesses at the top position
    repeat (14) send_word(CMD_PUSH_FRONT, pick_id(), $urandom, '0);
    send_word(CMD_PUSH_BACK, 32'h1111_1111, 32'h2222_2222, '0);
    send_word(CMD_PUSH_FRONT, 32'h3333_3333, 32'h4444_4444, '0);
    send_word(CMD_RETRIEVE, '0, '0, 4'd15);
    send_word(CMD_SEARCH, 32'h7FFF_FFFF, '0, '0);
    send_word(CMD_REMOVE, '0, '0, 4'd15);
    send_word(CMD_CLEAR, '0, '0, '0);
    send_word(CMD_CLEAR, '0, '0, '0);

    // alternate fill-heavy and drain-heavy phases, some with no gaps at all
    for (phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 1 || phase == 4);
      repeat (PHASE_WORDS)
        send_word(pick_command((phase % 2 == 0) ? 60 : 25), pick_id(), $urandom,
                  pick_position());
    end
    cmd_valid <= 1'b0;
    steady = 1'b0;

    // one edge first so the checker has counted the last word
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
sv/pls_pkg.sv
sv/positional_list_store.sv
tb/sv/list_store_checker.sv
tb/sv/testbench.sv
